FILE: rtl/shs_pkg.sv
// Shared types and constants for the streaming SHA-256 hasher.
// Used by shs_ctrl, shs_datapath and sha256_stream_hasher; depends on nothing.

package shs_pkg;

  typedef logic [31:0] word_t;

  localparam int HashWords  = 8;
  localparam int RoundCount = 64;

  // Codes carried on the action field of an input beat.
  localparam logic [1:0] ACT_ABSORB  = 2'd0;
  localparam logic [1:0] ACT_DIGEST  = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam word_t ROUND_K [RoundCount] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t H_INIT [HashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       buf_push;      // shift the absorbed byte into the block buffer
    logic       hash_restart;  // reload the initial hash, clear the counters
    logic       dig_start;     // copy buffer and chain value for a digest
    logic       pad_shift;     // shift one padding byte into the schedule
    logic       work_load;     // load the working variables for a block
    logic       round_step;    // run one compression round
    logic       fold;          // add the working variables into the hash
    logic       dig_mode;      // digest copy is the hash in use, else the chain value
    logic [5:0] rnd;           // round index
    logic [1:0] word_idx;      // digest word on the output
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_last;    // the buffer holds 63 bytes
    logic pad_blk_end;  // the current padding byte completes a block
    logic pad_done;     // all padding blocks have been built
  } sts_t;

endpackage

FILE: rtl/shs_ctrl.sv
// Sequencing state machine of the SHA-256 hasher: absorb, padding, rounds, output.
// Depends on shs_pkg for the command and status structs and the action codes.

module shs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         action,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  shs_pkg::sts_t      sts,
  output shs_pkg::cmd_t      cmd
);
  import shs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_PAD   = 6'b000100,
    S_ROUND = 6'b001000,
    S_FOLD  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic       mode, mode_next;
  logic [5:0] rnd, rnd_next;
  logic [1:0] word_idx, word_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode     <= 1'b0;
      rnd      <= '0;
      word_idx <= '0;
    end else begin
      state    <= state_next;
      mode     <= mode_next;
      rnd      <= rnd_next;
      word_idx <= word_idx_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next    = state;
    mode_next     = mode;
    rnd_next      = rnd;
    word_idx_next = word_idx;
    cmd           = '0;
    cmd.dig_mode  = mode;
    cmd.rnd       = rnd;
    cmd.word_idx  = word_idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (action)
            ACT_ABSORB: begin
              cmd.buf_push = 1'b1;
              if (sts.fill_last) begin
                mode_next  = 1'b0;
                state_next = S_LOAD;
              end
            end
            ACT_DIGEST: begin
              cmd.dig_start = 1'b1;
              mode_next     = 1'b1;
              state_next    = S_PAD;
            end
            ACT_RESTART: begin
              cmd.hash_restart = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_LOAD: begin
        cmd.work_load = 1'b1;
        rnd_next      = '0;
        state_next    = S_ROUND;
      end
      S_PAD: begin
        cmd.pad_shift = 1'b1;
        if (sts.pad_blk_end) begin
          cmd.work_load = 1'b1;
          rnd_next      = '0;
          state_next    = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round_step = 1'b1;
        rnd_next       = rnd + 6'd1;
        if (rnd == 6'(RoundCount - 1)) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (!mode) begin
          state_next = S_IDLE;
        end else if (sts.pad_done) begin
          word_idx_next = '0;
          state_next    = S_OUT;
        end else begin
          state_next = S_PAD;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          word_idx_next = word_idx + 2'd1;
          if (word_idx == 2'd3) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Input and output never open at the same time.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output handshakes open together");

  // The last round is always followed by the fold into the hash.
  a_round_to_fold: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rnd == 6'(RoundCount - 1)) |=> (state == S_FOLD))
    else $error("last round not followed by fold");

  // Taking the fourth digest word frees the input side.
  a_out_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && word_idx == 2'd3) |=> in_ready)
    else $error("block not idle after last digest word");

  // A digest only starts from idle and leads straight into padding.
  a_dig_pad: assert property (@(posedge clk) disable iff (rst)
    (in_ready && in_valid && action == ACT_DIGEST) |=> (state == S_PAD))
    else $error("digest request did not start padding");

endmodule

FILE: rtl/shs_datapath.sv
// Datapath of the SHA-256 hasher: block buffer, schedule window, round unit and hash words.
// Depends on shs_pkg for the constant tables and the command and status structs.

module shs_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         data_byte,
  input  shs_pkg::cmd_t      cmd,
  output shs_pkg::sts_t      sts,
  output logic [63:0]        digest_word,
  output logic               last_word
);
  import shs_pkg::*;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  logic [511:0] blk_buf;   // byte shift line, newest byte lowest
  logic [511:0] sched;     // schedule window, oldest word highest
  logic [5:0]   fill;
  logic [60:0]  total;
  logic [7:0]   pad_pos;
  word_t        chain [HashWords];
  word_t        dst   [HashWords];
  word_t        v     [HashWords];

  // Padding byte at the current position.
  logic [63:0] bit_count;
  logic [3:0]  len_hi;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;
  logic        two_blocks;

  assign two_blocks = (fill >= 6'd56);
  assign bit_count  = {total, 3'b000};
  assign len_hi     = two_blocks ? 4'd15 : 4'd7;
  assign len_byte   = bit_count[{~pad_pos[2:0], 3'b000} +: 8];

  always_comb begin
    if (pad_pos == {2'b00, fill}) begin
      pad_byte = 8'h80;
    end else if (pad_pos[6:3] == len_hi) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign sts.fill_last   = (fill == 6'd63);
  assign sts.pad_blk_end = (pad_pos[5:0] == 6'd63);
  assign sts.pad_done    = (pad_pos == (two_blocks ? 8'd128 : 8'd64));

  // Round arithmetic.
  word_t w_cur, w_new, sg0, sg1, big0, big1, choose, major, tmp1;
  word_t x15, x2;

  assign w_cur  = sched[511:480];
  assign x15    = sched[479:448];
  assign x2     = sched[63:32];
  assign sg0    = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
  assign sg1    = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
  assign w_new  = w_cur + sg0 + sched[223:192] + sg1;
  assign big1   = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
  assign choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign tmp1   = v[7] + big1 + choose + ROUND_K[cmd.rnd] + w_cur;
  assign big0   = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
  assign major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);

  // Counters and the chaining value are control state.
  always_ff @(posedge clk) begin
    if (rst || cmd.hash_restart) begin
      fill  <= '0;
      total <= '0;
      for (int i = 0; i < HashWords; i++) begin
        chain[i] <= H_INIT[i];
      end
    end else begin
      if (cmd.buf_push) begin
        fill  <= fill + 6'd1;
        total <= total + 61'd1;
      end
      if (cmd.fold && !cmd.dig_mode) begin
        for (int i = 0; i < HashWords; i++) begin
          chain[i] <= chain[i] + v[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.buf_push) begin
      blk_buf <= {blk_buf[503:0], data_byte};
    end

    if (cmd.dig_start) begin
      sched   <= blk_buf;
      pad_pos <= {2'b00, fill};
    end else if (cmd.pad_shift) begin
      sched   <= {sched[503:0], pad_byte};
      pad_pos <= pad_pos + 8'd1;
    end else if (cmd.work_load && !cmd.dig_mode) begin
      sched <= blk_buf;
    end else if (cmd.round_step) begin
      sched <= {sched[479:0], w_new};
    end

    if (cmd.dig_start) begin
      for (int i = 0; i < HashWords; i++) begin
        dst[i] <= chain[i];
      end
    end else if (cmd.fold && cmd.dig_mode) begin
      for (int i = 0; i < HashWords; i++) begin
        dst[i] <= dst[i] + v[i];
      end
    end

    if (cmd.work_load) begin
      for (int i = 0; i < HashWords; i++) begin
        v[i] <= cmd.dig_mode ? dst[i] : chain[i];
      end
    end else if (cmd.round_step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + tmp1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= tmp1 + big0 + major;
    end
  end

  assign digest_word = {dst[{cmd.word_idx, 1'b0}], dst[{cmd.word_idx, 1'b1}]};
  assign last_word   = (cmd.word_idx == 2'd3);

endmodule

FILE: rtl/sha256_stream_hasher.sv
// Top level of the streaming SHA-256 hasher.
// Depends on shs_pkg, shs_ctrl and shs_datapath.

// Incremental SHA-256 over a byte stream. Each input beat carries an action in
// s_tuser: absorb takes the byte in s_tdata, digest sends out the hash of all
// bytes absorbed since the last restart as four 64-bit big-endian words (the
// fourth marked by m_tlast) without disturbing the running hash, and restart
// reloads the initial hash values. Action code 3 is ignored. The byte that
// completes a 64-byte block starts the single round unit, which runs its 64
// rounds, one per cycle, with a load step before and a fold step after. A
// digest shifts the padding after the pending bytes into the schedule window
// and runs the rounds and the fold; with 56 or more bytes pending it builds
// and compresses a second padded block too. The output beats then follow,
// one per cycle while m_tready is high. The block handles one item at a
// time: s_tready is low from the acceptance of a full-block absorb or a
// digest until its work, including all four output beats, is done. The
// message length counter wraps modulo 2^61 bytes, as the 64-bit bit count in
// the padding does.

module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic [1:0]  s_tuser,    // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,    // [63:0] digest_word
  output logic        m_tlast     // last_word
);
  import shs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller only sees the action; the byte goes straight to the buffer.
  shs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .action    (s_tuser),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Digest words are read from the digest copy of the hash, which holds still
  // while the output beats wait for m_tready.
  shs_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (s_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .digest_word (m_tdata),
    .last_word   (m_tlast)
  );

endmodule
